@@ design/hcbd_pkg.sv @@
// Shared types, constants and helpers for the HTTP chunked body decoder.
package hcbd_pkg;

    localparam int SIZE_BITS  = 24;
    localparam int POS_BITS   = 32;
    localparam int BYTE_BITS  = 8;
    localparam int KIND_BITS  = 3;
    localparam int S_DATA_W   = 8;
    localparam int S_USER_W   = 1;
    localparam int M_DATA_W   = BYTE_BITS + POS_BITS;
    localparam int M_USER_W   = KIND_BITS;

    localparam logic [BYTE_BITS-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_BITS-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_BITS-1:0] CH_TAB   = 8'h09;

    typedef enum logic [2:0] {
        PH_LWS     = 3'd0,
        PH_HEX     = 3'd1,
        PH_REST    = 3'd2,
        PH_DATA    = 3'd3,
        PH_CR      = 3'd4,
        PH_LF      = 3'd5,
        PH_TRAILER = 3'd6,
        PH_DONE    = 3'd7
    } phase_t;

    typedef enum logic [KIND_BITS-1:0] {
        K_NONE    = 3'd0,
        K_DATA    = 3'd1,
        K_FINISH  = 3'd2,
        K_ERROR   = 3'd3,
        K_IGNORED = 3'd4
    } kind_t;

    typedef struct packed {
        phase_t               phase;
        logic [SIZE_BITS-1:0] size_left;
        logic                 saw_digit;
        logic                 last_was_cr;
        logic [POS_BITS-1:0]  position;
    } dec_state_t;

    typedef struct packed {
        kind_t                kind;
        logic [BYTE_BITS-1:0] data_byte;
        logic [POS_BITS-1:0]  consumed_count;
    } result_t;

    localparam dec_state_t STATE_CLEAR = '{
        phase:       PH_LWS,
        size_left:   '0,
        saw_digit:   1'b0,
        last_was_cr: 1'b0,
        position:    '0
    };

    // {is_hex, nibble}
    function automatic logic [4:0] hex_decode(input logic [BYTE_BITS-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

@@ design/http_chunked_body_decoder.sv @@
// Top level of the HTTP chunked body decoder: stream ports, state and offset registers.
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------------
//  s_       | in        | tdata[7:0] in_byte; tuser[0] restart
//  m_       | out       | tdata[7:0] data_byte, [39:8] consumed_count; tuser[2:0] kind
//  cfg_     | in        | cfg_data[31:0] start_offset
//
// One byte per cycle is taken while s_tready is high; its result reaches m_ through the result
// register or the skid entry. The decoder state is updated in the same cycle a byte is taken.
// aresetn (synchronous) clears the decoder state, start_offset and the output stage.
// With m_tready low, one further byte is held in the skid entry before s_tready drops.
module http_chunked_body_decoder (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [hcbd_pkg::S_DATA_W-1:0]      s_tdata,   // [7:0] in_byte
    input  logic [hcbd_pkg::S_USER_W-1:0]      s_tuser,   // [0] restart
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [hcbd_pkg::M_DATA_W-1:0]      m_tdata,   // [7:0] data_byte, [39:8] consumed_count
    output logic [hcbd_pkg::M_USER_W-1:0]      m_tuser,   // [2:0] kind
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hcbd_pkg::POS_BITS-1:0]      cfg_data
);
    import hcbd_pkg::*;

    dec_state_t          state_reg, state_next;
    logic [POS_BITS-1:0] offset_reg;
    result_t             step_res;
    result_t             out_res;
    logic                s_xfer;

    assign cfg_ready = 1'b1;
    assign s_xfer    = s_tvalid && s_tready;

    // decode step, pure logic
    hcbd_step u_step (
        .state_i        (state_reg),
        .in_byte_i      (s_tdata[BYTE_BITS-1:0]),
        .restart_i      (s_tuser[0]),
        .start_offset_i (offset_reg),
        .state_o        (state_next),
        .result_o       (step_res)
    );

    // decoder state advances only on an accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_CLEAR;
        end else if (s_xfer) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            offset_reg <= cfg_data;
        end
    end

    // result register plus skid entry
    hcbd_out_buf u_out_buf (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_i      (s_xfer),
        .push_data_i (step_res),
        .ready_o     (s_tready),
        .valid_o     (m_tvalid),
        .pop_ready_i (m_tready),
        .data_o      (out_res)
    );

    assign m_tdata = {out_res.consumed_count, out_res.data_byte};
    assign m_tuser = out_res.kind;

    // after every accepted byte, m_tvalid is high on the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> m_tvalid)
        else $error("no result after accepted transaction");

    // data bytes only come out of the data phase, with zero data otherwise
    a_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != K_DATA) |-> (m_tdata[BYTE_BITS-1:0] == '0))
        else $error("data byte set on non-data result");

    // once finished or failed, only ignored results until restart
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && state_reg.phase == PH_DONE && !s_tuser[0]) |=> (state_reg.phase == PH_DONE))
        else $error("left done phase without restart");

endmodule

@@ design/hcbd_step.sv @@
// Per-byte decode step: next decoder state and result from one input byte.
module hcbd_step (
    input  hcbd_pkg::dec_state_t              state_i,
    input  logic [hcbd_pkg::BYTE_BITS-1:0]    in_byte_i,
    input  logic                              restart_i,
    input  logic [hcbd_pkg::POS_BITS-1:0]     start_offset_i,
    output hcbd_pkg::dec_state_t              state_o,
    output hcbd_pkg::result_t                 result_o
);
    import hcbd_pkg::*;

    dec_state_t           eff;
    logic                 is_hex;
    logic [3:0]           nib;
    logic                 line_end;
    logic                 size_ovf;
    logic [SIZE_BITS-1:0] size_dec;

    always_comb begin
        eff      = restart_i ? STATE_CLEAR : state_i;
        {is_hex, nib} = hex_decode(in_byte_i);
        line_end = (in_byte_i == CH_LF) && eff.last_was_cr;
        size_ovf = (eff.size_left[SIZE_BITS-1 -: 4] != 4'd0);
        size_dec = eff.size_left - SIZE_BITS'(1);
    end

    // next state
    always_comb begin
        state_o = eff;
        if (eff.phase != PH_DONE) begin
            state_o.position = eff.position + POS_BITS'(1);
            case (eff.phase)
                PH_LWS, PH_HEX, PH_REST, PH_TRAILER: begin
                    if (line_end) begin
                        state_o.last_was_cr = 1'b0;
                        if (eff.phase == PH_TRAILER || !eff.saw_digit) begin
                            state_o.phase = PH_DONE;
                        end else if (eff.size_left == '0) begin
                            state_o.phase = PH_TRAILER;
                        end else begin
                            state_o.phase = PH_DATA;
                        end
                    end else begin
                        state_o.last_was_cr = (in_byte_i == CH_CR);
                        if (eff.phase == PH_LWS) begin
                            if (in_byte_i == CH_SPACE || in_byte_i == CH_TAB) begin
                                state_o.phase = PH_LWS;
                            end else if (is_hex) begin
                                state_o.size_left = SIZE_BITS'(nib);
                                state_o.saw_digit = 1'b1;
                                state_o.phase     = PH_HEX;
                            end else begin
                                state_o.phase = PH_REST;
                            end
                        end else if (eff.phase == PH_HEX) begin
                            if (is_hex) begin
                                if (size_ovf) begin
                                    state_o.phase = PH_DONE;
                                end else begin
                                    state_o.size_left = {eff.size_left[SIZE_BITS-5:0], nib};
                                end
                            end else begin
                                state_o.phase = PH_REST;
                            end
                        end
                    end
                end
                PH_DATA: begin
                    state_o.size_left = size_dec;
                    if (size_dec == '0) state_o.phase = PH_CR;
                end
                PH_CR: begin
                    state_o.phase = (in_byte_i == CH_CR) ? PH_LF : PH_DONE;
                end
                PH_LF: begin
                    if (in_byte_i == CH_LF) begin
                        state_o.phase       = PH_LWS;
                        state_o.size_left   = '0;
                        state_o.saw_digit   = 1'b0;
                        state_o.last_was_cr = 1'b0;
                    end else begin
                        state_o.phase = PH_DONE;
                    end
                end
                default: state_o.phase = PH_DONE;
            endcase
        end
    end

    // result
    always_comb begin
        result_o.kind           = K_NONE;
        result_o.data_byte      = '0;
        result_o.consumed_count = start_offset_i + state_o.position;
        case (eff.phase)
            PH_DONE: result_o.kind = K_IGNORED;
            PH_LWS, PH_HEX, PH_REST, PH_TRAILER: begin
                if (line_end) begin
                    if (eff.phase == PH_TRAILER) begin
                        result_o.kind = K_FINISH;
                    end else if (!eff.saw_digit) begin
                        result_o.kind = K_ERROR;
                    end
                end else if (eff.phase == PH_HEX && is_hex && size_ovf) begin
                    result_o.kind = K_ERROR;
                end
            end
            PH_DATA: begin
                result_o.kind      = K_DATA;
                result_o.data_byte = in_byte_i;
            end
            PH_CR: if (in_byte_i != CH_CR) result_o.kind = K_ERROR;
            PH_LF: if (in_byte_i != CH_LF) result_o.kind = K_ERROR;
            default: result_o.kind = K_NONE;
        endcase
    end

endmodule

@@ design/hcbd_out_buf.sv @@
// Result register with a skid entry, so the input side can take one more result under stall.
module hcbd_out_buf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_i,
    input  hcbd_pkg::result_t  push_data_i,
    output logic               ready_o,
    output logic               valid_o,
    input  logic               pop_ready_i,
    output hcbd_pkg::result_t  data_o
);
    import hcbd_pkg::*;

    logic    main_v_reg, main_v_next;
    logic    skid_v_reg, skid_v_next;
    result_t main_reg,   main_next;
    result_t skid_reg,   skid_next;
    logic    pop;

    assign pop     = main_v_reg && pop_ready_i;
    assign ready_o = !skid_v_reg;
    assign valid_o = main_v_reg;
    assign data_o  = main_reg;

    always_comb begin
        main_v_next = main_v_reg;
        skid_v_next = skid_v_reg;
        main_next   = main_reg;
        skid_next   = skid_reg;
        if (pop || !main_v_reg) begin
            if (skid_v_reg) begin
                main_next   = skid_reg;
                main_v_next = 1'b1;
                skid_v_next = 1'b0;
            end else begin
                main_next   = push_data_i;
                main_v_next = push_i;
            end
        end else if (push_i) begin
            skid_next   = push_data_i;
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            main_v_reg <= main_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule
